// File: rtl/core/krt_pkg.sv
// ============================================================================
// krt_pkg: shared types and codes of the keyed record table
// Field widths, command and status codes, the stored record layout, and the
// command/status bundles between the controller and the datapath.
// ============================================================================
package krt_pkg;

  // Field widths
  localparam int KIND_W = 3;
  localparam int KEY_W  = 16;
  localparam int SECT_W = 4;
  localparam int SAL_W  = 24;
  localparam int SLOT_W = 4;
  localparam int STAT_W = 2;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SORT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // One stored record
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SECT_W-1:0] sector;
    logic [SAL_W-1:0]  salary;
  } record_t;

  // One result beat
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [SECT_W-1:0] sector;
    logic [SAL_W-1:0]  salary;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch the request beat, clear the result
    logic start;     // begin a scan from slot zero
    logic advance;   // step the sort position and scan from there
    logic act;       // apply the command once the scan is complete
    logic swap_p;    // write the minimum record at the sort position
    logic swap_m;    // write the displaced record where the minimum was
    logic load_out;  // move the result into the output register
  } krt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_busy;
    logic is_sort;
    logic best_found;
    logic best_at_pos;
    logic pos_last;
  } krt_stat_t;

endpackage

// File: rtl/core/krt_in_if.sv
// ============================================================================
// krt_in_if: request channel of the keyed record table
// Valid/ready handshake carrying one command beat.
// ============================================================================
interface krt_in_if;
  import krt_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  record_key;
  logic [SECT_W-1:0] sector_id;
  logic [SAL_W-1:0]  salary;
  logic [SLOT_W-1:0] slot;

  modport source (
    output valid, kind, record_key, sector_id, salary, slot,
    input  ready
  );

  modport sink (
    input  valid, kind, record_key, sector_id, salary, slot,
    output ready
  );
endinterface

// File: rtl/core/krt_out_if.sv
// ============================================================================
// krt_out_if: response channel of the keyed record table
// Valid/ready handshake carrying one result beat.
// ============================================================================
interface krt_out_if;
  import krt_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] out_slot;
  logic              out_valid;
  logic [KEY_W-1:0]  out_key;
  logic [SECT_W-1:0] out_sector;
  logic [SAL_W-1:0]  out_salary;

  modport source (
    output valid, status, out_slot, out_valid, out_key, out_sector, out_salary,
    input  ready
  );

  modport sink (
    input  valid, status, out_slot, out_valid, out_key, out_sector, out_salary,
    output ready
  );
endinterface

// File: rtl/core/krt_datapath.sv
// ============================================================================
// krt_datapath: record storage, slot scanner and result registers
// Holds the record memory and valid bits, scans one slot per cycle for key
// matches, the first free slot and the minimum key, and performs the writes.
// ============================================================================
module krt_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  krt_pkg::krt_cmd_t           cmd,
  output krt_pkg::krt_stat_t          stat,
  input  logic [krt_pkg::KIND_W-1:0]  in_kind,
  input  logic [krt_pkg::KEY_W-1:0]   in_key,
  input  logic [krt_pkg::SECT_W-1:0]  in_sector,
  input  logic [krt_pkg::SAL_W-1:0]   in_salary,
  input  logic [krt_pkg::SLOT_W-1:0]  in_slot,
  output krt_pkg::result_t            result
);
  import krt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // Latched request
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  logic [SECT_W-1:0] sector;
  logic [SAL_W-1:0]  salary;
  logic [SLOT_W-1:0] slot;

  // Storage
  logic [DEPTH-1:0] valid;
  record_t          mem [DEPTH];
  record_t          rdata;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  record_t          wr_data;

  // Scanner
  logic          scan_run;
  logic [AW-1:0] scan_idx;
  logic          cmp_live;
  logic [AW-1:0] cmp_idx;
  logic [AW-1:0] pos;
  logic          cmp_valid;

  // Scan findings
  logic          found;
  logic [AW-1:0] found_idx;
  record_t       found_rec;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          best_found;
  logic [AW-1:0] best_idx;
  record_t       best_rec;
  record_t       head_rec;

  // Read slot decode
  logic [CW-1:0] slot_ext;
  logic          slot_in_range;
  logic [AW-1:0] slot_addr;

  // Results
  result_t res;
  result_t out_q;

  logic insert_ok;
  logic key_ok;

  assign slot_ext      = CW'(slot);
  assign slot_in_range = slot_ext < CW'(DEPTH);
  assign slot_addr     = slot_ext[AW-1:0];
  assign rd_addr       = scan_run ? scan_idx : slot_addr;
  assign cmp_valid     = valid[cmp_idx];

  assign insert_ok = cmd.act && (kind == KIND_INSERT) && free_found && !found;
  assign key_ok    = cmd.act && found;

  // Latch the request beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind   <= in_kind;
      key    <= in_key;
      sector <= in_sector;
      salary <= in_salary;
      slot   <= in_slot;
    end
  end

  // Select the single memory write of this cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = free_idx;
    wr_data = '{key: key, sector: sector, salary: salary};
    if (insert_ok) begin
      wr_en = 1'b1;
    end else if (key_ok && (kind == KIND_UPDATE)) begin
      wr_en   = 1'b1;
      wr_addr = found_idx;
      wr_data = '{key: found_rec.key, sector: found_rec.sector, salary: salary};
    end else if (cmd.swap_p) begin
      wr_en   = 1'b1;
      wr_addr = pos;
      wr_data = best_rec;
    end else if (cmd.swap_m) begin
      wr_en   = 1'b1;
      wr_addr = best_idx;
      wr_data = head_rec;
    end
  end

  // Record memory, registered read
  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (insert_ok) begin
      valid[free_idx] <= 1'b1;
    end else if (key_ok && (kind == KIND_DELETE)) begin
      valid[found_idx] <= 1'b0;
    end else if (cmd.swap_p) begin
      valid[pos]      <= 1'b1;
      valid[best_idx] <= valid[pos];
    end
  end

  // Scan control: issue one slot address a cycle, compare it in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_run <= 1'b0;
      cmp_live <= 1'b0;
    end else begin
      cmp_live <= scan_run;
      if (cmd.start || cmd.advance) begin
        scan_run <= 1'b1;
      end else if (scan_run && (scan_idx == LAST)) begin
        scan_run <= 1'b0;
      end
    end
  end

  // Scan address and sort position
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cmd.start) begin
      scan_idx <= '0;
    end else if (cmd.advance) begin
      scan_idx <= pos + AW'(1);
    end else if (scan_run) begin
      scan_idx <= scan_idx + AW'(1);
    end
    if (cmd.accept) begin
      pos <= '0;
    end else if (cmd.advance) begin
      pos <= pos + AW'(1);
    end
  end

  // Gather key match, first free slot and minimum key
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else if (cmd.start || cmd.advance) begin
      found      <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else if (cmp_live) begin
      if (cmp_valid && (rdata.key == key) && !found) begin
        found <= 1'b1;
      end
      if (!cmp_valid && !free_found) begin
        free_found <= 1'b1;
      end
      if (cmp_valid && (!best_found || (rdata.key < best_rec.key))) begin
        best_found <= 1'b1;
      end
    end
  end

  // Capture indexes and records alongside the flags
  always_ff @(posedge clk) begin
    if (cmp_live) begin
      if (cmp_valid && (rdata.key == key) && !found) begin
        found_idx <= cmp_idx;
        found_rec <= rdata;
      end
      if (!cmp_valid && !free_found) begin
        free_idx <= cmp_idx;
      end
      if (cmp_valid && (!best_found || (rdata.key < best_rec.key))) begin
        best_idx <= cmp_idx;
        best_rec <= rdata;
      end
      if (cmp_idx == pos) begin
        head_rec <= rdata;
      end
    end
  end

  // Build the result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res <= '0;
    end else if (cmd.act) begin
      case (kind)
        KIND_INSERT: begin
          if (!free_found) begin
            res.status <= ST_FULL;
          end else if (found) begin
            res.status <= ST_DUP;
          end else begin
            res.slot <= SLOT_W'(free_idx);
          end
        end
        KIND_DELETE, KIND_UPDATE: begin
          if (!found) begin
            res.status <= ST_NOTFOUND;
          end else begin
            res.slot <= SLOT_W'(found_idx);
          end
        end
        KIND_READ: begin
          if (slot_in_range && valid[slot_addr]) begin
            res.valid  <= 1'b1;
            res.key    <= rdata.key;
            res.sector <= rdata.sector;
            res.salary <= rdata.salary;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_q <= res;
    end
  end

  assign result = out_q;

  assign stat.scan_busy   = scan_run | cmp_live;
  assign stat.is_sort     = (kind == KIND_SORT);
  assign stat.best_found  = best_found;
  assign stat.best_at_pos = (best_idx == pos);
  assign stat.pos_last    = (pos == LAST);

  // Every issued address reaches the comparator on the next cycle
  a_scan_drain: assert property (@(posedge clk) disable iff (rst)
    scan_run |=> cmp_live)
    else $error("scan address issued without a following compare");

  // The second half of a swap follows a filled sort position
  a_swap_pos_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.swap_m |-> valid[pos])
    else $error("sort position empty during swap");

endmodule

// File: rtl/core/krt_ctrl.sv
// ============================================================================
// krt_ctrl: command sequencer of the keyed record table
// Takes request beats, runs slot scans and sort passes on the datapath, and
// hands results to the output register when it is free.
// ============================================================================
module krt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [krt_pkg::KIND_W-1:0] in_kind,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  krt_pkg::krt_stat_t         stat,
  output krt_pkg::krt_cmd_t          cmd
);
  import krt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_RD     = 7'b0000100,
    S_ACT    = 7'b0001000,
    S_SWAP_P = 7'b0010000,
    S_SWAP_M = 7'b0100000,
    S_REPLY  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_kind)
            KIND_INSERT, KIND_DELETE, KIND_UPDATE, KIND_SORT: begin
              cmd.start  = 1'b1;
              state_next = S_SCAN;
            end
            KIND_READ: state_next = S_RD;
            default:   state_next = S_REPLY;
          endcase
        end
      end
      S_SCAN: begin
        if (!stat.scan_busy) begin
          state_next = S_ACT;
        end
      end
      S_RD: state_next = S_ACT;
      S_ACT: begin
        cmd.act = 1'b1;
        if (!stat.is_sort || !stat.best_found) begin
          state_next = S_REPLY;
        end else if (!stat.best_at_pos) begin
          state_next = S_SWAP_P;
        end else if (stat.pos_last) begin
          state_next = S_REPLY;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SWAP_P: begin
        cmd.swap_p = 1'b1;
        state_next = S_SWAP_M;
      end
      S_SWAP_M: begin
        cmd.swap_m = 1'b1;
        if (stat.pos_last) begin
          state_next = S_REPLY;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_REPLY: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output beat pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A swap is entered only with a minimum found away from the sort position
  a_swap_cause: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP_P) |-> (stat.best_found && !stat.best_at_pos))
    else $error("swap without a displaced minimum");

  // Scan findings are used only after the scanner has drained
  a_act_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT) |-> !stat.scan_busy)
    else $error("command applied while the scan is still running");

endmodule

// File: rtl/core/keyed_record_table_unit.sv
// ============================================================================
// keyed_record_table_unit: fixed-slot keyed record table
// Table of DEPTH records (key, sector, salary) with insert, delete, salary
// update, sort by key and slot read, one result beat per request beat.
// ============================================================================
// Usage:
//   request  (sink)  : one command beat per valid/ready handshake.
//   response (source): exactly one result beat per request, in order.
//   Requests are taken one at a time; ready is high while the sequencer is
//   idle, including while a previous result still waits in the output
//   register.
//   Work per request beat:
//     read, unused kinds      : no slot scan
//     insert, delete, update  : one full slot scan at one slot per cycle
//                               through the record memory
//     sort                    : a selection pass per position, each a
//                               scan of the remaining slots plus, when the
//                               minimum is not already at the position, a
//                               swap through the single memory write port
//   Reset (synchronous, active high) marks every slot empty at once.
//   When the receiver stalls, the result holds in the output register; the
//   next request is still accepted and is held before its reply until the
//   output register frees.
// ============================================================================
module keyed_record_table_unit #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  krt_in_if.sink    request,
  krt_out_if.source response
);
  import krt_pkg::*;

  krt_cmd_t  cmd;
  krt_stat_t stat;
  result_t   result;

  krt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_kind   (request.kind),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  krt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_kind   (request.kind),
    .in_key    (request.record_key),
    .in_sector (request.sector_id),
    .in_salary (request.salary),
    .in_slot   (request.slot),
    .result    (result)
  );

  assign response.status     = result.status;
  assign response.out_slot   = result.slot;
  assign response.out_valid  = result.valid;
  assign response.out_key    = result.key;
  assign response.out_sector = result.sector;
  assign response.out_salary = result.salary;

endmodule

// File: test/krt_table_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// krt_table_checker: result checker for the keyed record table
// Watches the request and response channels, keeps its own copy of the
// table, works out the reply to every accepted request and compares each
// reply beat field by field with the oldest reply still due.
// ============================================================================
module krt_table_checker #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  krt_in_if    req,
  krt_out_if   resp,
  output int   errors,
  output int   outstanding
);
  import krt_pkg::*;

  logic    occupied [DEPTH];
  record_t rows     [DEPTH];
  result_t replies_due [$];

  // Apply one command to the shadow table and return the reply it should give
  function automatic result_t predict_reply(logic [KIND_W-1:0] kind, record_t rec,
                                            logic [SLOT_W-1:0] pick);
    result_t r;
    record_t ordered [DEPTH];
    int      hit;
    int      free;
    int      n;
    int      j;
    r    = '0;
    hit  = DEPTH;
    free = DEPTH;
    n    = 0;
    // lowest empty slot and lowest valid slot holding the key
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!occupied[i]) free = i;
      if (occupied[i] && rows[i].key == rec.key) hit = i;
    end
    case (kind)
      KIND_INSERT: begin
        if (free == DEPTH) begin
          r.status = ST_FULL;
        end else if (hit < DEPTH) begin
          r.status = ST_DUP;
        end else begin
          occupied[free] = 1'b1;
          rows[free]     = rec;
          r.slot         = SLOT_W'(free);
        end
      end
      KIND_DELETE: begin
        if (hit == DEPTH) begin
          r.status = ST_NOTFOUND;
        end else begin
          occupied[hit] = 1'b0;
          r.slot        = SLOT_W'(hit);
        end
      end
      KIND_UPDATE: begin
        if (hit == DEPTH) begin
          r.status = ST_NOTFOUND;
        end else begin
          rows[hit].salary = rec.salary;
          r.slot           = SLOT_W'(hit);
        end
      end
      KIND_SORT: begin
        // stable insertion sort of the valid records, then repack
        for (int i = 0; i < DEPTH; i++) begin
          if (occupied[i]) begin
            j = n;
            while (j > 0 && ordered[j-1].key > rows[i].key) begin
              ordered[j] = ordered[j-1];
              j--;
            end
            ordered[j] = rows[i];
            n++;
          end
        end
        for (int i = 0; i < DEPTH; i++) begin
          occupied[i] = (i < n);
          rows[i]     = (i < n) ? ordered[i] : record_t'('0);
        end
      end
      KIND_READ: begin
        if (int'(pick) < DEPTH && occupied[pick]) begin
          r.valid  = 1'b1;
          r.key    = rows[pick].key;
          r.sector = rows[pick].sector;
          r.salary = rows[pick].salary;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Track request beats and check response beats
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        occupied[i] = 1'b0;
        rows[i]     = '0;
      end
      replies_due.delete();
      errors = 0;
    end else begin
      if (req.valid && req.ready) begin
        replies_due.push_back(predict_reply(req.kind,
                                            {req.record_key, req.sector_id, req.salary},
                                            req.slot));
      end
      if (resp.valid && resp.ready) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: reply beat with none due, expected nothing, got status %0h slot %0h",
                   $time, resp.status, resp.out_slot);
        end else begin
          want = replies_due.pop_front();
          compare_field("status", 32'(want.status), 32'(resp.status));
          compare_field("out_slot", 32'(want.slot), 32'(resp.out_slot));
          compare_field("out_valid", 32'(want.valid), 32'(resp.out_valid));
          compare_field("out_key", 32'(want.key), 32'(resp.out_key));
          compare_field("out_sector", 32'(want.sector), 32'(resp.out_sector));
          compare_field("out_salary", 32'(want.salary), 32'(resp.out_salary));
        end
      end
    end
    outstanding = replies_due.size();
  end
endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: keyed record table stimulus and verdict
// Drives directed commands that fill, overfill, search, sort and read the
// table, then random command streams over a small pool of keys so that hits,
// duplicates and a full table are common. Both channels idle in random
// bursts; the response side once holds off long enough to back up requests.
// ============================================================================
module testbench;
  import krt_pkg::*;

  localparam int DEPTH       = 16;
  localparam int ITEMS       = 1300;
  localparam int CALM_ITEMS  = 150;
  localparam int POOL_SIZE   = 20;
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_AFTER  = 500;
  localparam int HOLD_CYCLES = 300;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic clk;
  logic rst;
  bit   calm_tail;
  int   errors;
  int   outstanding;

  krt_in_if  req ();
  krt_out_if resp ();

  keyed_record_table_unit #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req),
    .response (resp)
  );

  krt_table_checker #(.DEPTH(DEPTH)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .resp        (resp),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort when no beat moves on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (resp.valid && resp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Response side: random stall bursts, one long hold-off, none in the tail
  initial begin : reply_sink
    int taken;
    int stall;
    bit held;
    taken      = 0;
    stall      = 0;
    held       = 1'b0;
    resp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (resp.valid && resp.ready) taken++;
      @(negedge clk);
      if (stall > 0) begin
        stall--;
      end else if (!held && taken >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19);
      end
      resp.ready = (stall == 0) && !rst;
    end
  end

  // Offer one request beat, maybe after an idle burst, and hold until taken
  task automatic issue_command(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [SECT_W-1:0] sector, logic [SAL_W-1:0] salary,
                               logic [SLOT_W-1:0] slot);
    @(negedge clk);
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req.valid      = 1'b1;
    req.kind       = kind;
    req.record_key = key;
    req.sector_id  = sector;
    req.salary     = salary;
    req.slot       = slot;
    do @(posedge clk); while (!req.ready);
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];
    logic [KEY_W-1:0]  key;
    logic [KIND_W-1:0] kind;
    logic [SECT_W-1:0] sector;
    logic [SAL_W-1:0]  salary;
    int                roll;
    rst            = 1'b1;
    calm_tail      = 1'b0;
    req.valid      = 1'b0;
    req.kind       = KIND_INSERT;
    req.record_key = '0;
    req.sector_id  = '0;
    req.salary     = '0;
    req.slot       = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Read an empty slot, then fill the table with descending keys
    issue_command(KIND_READ, '0, '0, '0, 4'd15);
    for (int i = 0; i < DEPTH; i++) begin
      key    = 16'hFFFF - 16'(16'h1111 * i);
      sector = (i == 0) ? 4'hF : (i == DEPTH - 1) ? 4'h0 : 4'($urandom_range(0, 15));
      salary = (i == 0) ? 24'hFFFFFF : (i == DEPTH - 1) ? 24'h0 :
               24'($urandom_range(0, 24'hFFFFFF));
      issue_command(KIND_INSERT, key, sector, salary, '0);
    end
    // Full table, then delete, duplicate, missing key, update, sort, reads
    issue_command(KIND_INSERT, 16'h1234, 4'h3, 24'h000123, '0);
    issue_command(KIND_DELETE, 16'h7777, '0, '0, '0);
    issue_command(KIND_INSERT, 16'hFFFF, 4'h1, 24'h000001, '0);
    issue_command(KIND_UPDATE, 16'h7777, '0, 24'h00ABCD, '0);
    issue_command(KIND_UPDATE, 16'hFFFF, '0, 24'h0, '0);
    issue_command(KIND_SORT, '0, '0, '0, '0);
    issue_command(KIND_READ, '0, '0, '0, 4'd0);
    issue_command(KIND_READ, '0, '0, '0, 4'd15);
    issue_command(KIND_SPARE_HI, 16'hFFFF, 4'hF, 24'hFFFFFF, 4'hF);

    // Random commands over a slowly changing pool of keys
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom_range(0, 16'hFFFF));
    for (int n = 0; n < ITEMS; n++) begin
      calm_tail = (n >= ITEMS - CALM_ITEMS);
      if ($urandom_range(0, 19) == 0)
        key_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom_range(0, 16'hFFFF));
      key  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 16'hFFFF)) :
             key_pool[$urandom_range(0, POOL_SIZE - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 40)      kind = KIND_INSERT;
      else if (roll < 60) kind = KIND_DELETE;
      else if (roll < 72) kind = KIND_UPDATE;
      else if (roll < 76) kind = KIND_SORT;
      else if (roll < 94) kind = KIND_READ;
      else                kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      issue_command(kind, key, 4'($urandom_range(0, 15)),
                    24'($urandom_range(0, 24'hFFFFFF)), 4'($urandom_range(0, 15)));
    end

    // Drain, then allow a short window for any stray reply beat
    @(negedge clk);
    req.valid = 1'b0;
    wait (outstanding == 0);
    repeat (DEPTH + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
